@@ src/gmw_pkg.sv @@
// Package: shared constants, types and mask table for the grid MWIS core.
`default_nettype none
package gmw_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int W_W       = 16;
    localparam int ROWS_W    = 4;
    localparam int SCORE_W   = 48;
    localparam int OUT_W     = 47;
    localparam int COLW_W    = W_W + 3;
    localparam int NUM_MASKS = 55;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = MAX_ROWS + 1;

    // row masks of MAX_ROWS bits with no two adjacent bits set
    localparam logic [MAX_ROWS-1:0] MASKS [0:NUM_MASKS-1] = '{
        8'd0,   8'd1,   8'd2,   8'd4,   8'd5,   8'd8,   8'd9,   8'd10,
        8'd16,  8'd17,  8'd18,  8'd20,  8'd21,  8'd32,  8'd33,  8'd34,
        8'd36,  8'd37,  8'd40,  8'd41,  8'd42,  8'd64,  8'd65,  8'd66,
        8'd68,  8'd69,  8'd72,  8'd73,  8'd74,  8'd80,  8'd81,  8'd82,
        8'd84,  8'd85,  8'd128, 8'd129, 8'd130, 8'd132, 8'd133, 8'd136,
        8'd137, 8'd138, 8'd144, 8'd145, 8'd146, 8'd148, 8'd149, 8'd160,
        8'd161, 8'd162, 8'd164, 8'd165, 8'd168, 8'd169, 8'd170
    };

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MASKS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                load;
        logic                acc_en;
        logic                wr_en;
        logic [MAX_ROWS-1:0] cur_mask;
    } ctrl_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } mem_req_t;

endpackage
`default_nettype wire

@@ src/gmw_if.sv @@
// Interfaces: column input, result output and configuration write channels.
`default_nettype none
interface gmw_in_if;
    import gmw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [W_W-1:0] weight_0;
    logic signed [W_W-1:0] weight_1;
    logic signed [W_W-1:0] weight_2;
    logic signed [W_W-1:0] weight_3;
    logic signed [W_W-1:0] weight_4;
    logic signed [W_W-1:0] weight_5;
    logic signed [W_W-1:0] weight_6;
    logic signed [W_W-1:0] weight_7;
    logic                  first_column;
    logic                  last_column;

    modport source (
        output valid, weight_0, weight_1, weight_2, weight_3,
               weight_4, weight_5, weight_6, weight_7, first_column, last_column,
        input  ready
    );
    modport sink (
        input  valid, weight_0, weight_1, weight_2, weight_3,
               weight_4, weight_5, weight_6, weight_7, first_column, last_column,
        output ready
    );
endinterface

interface gmw_out_if;
    import gmw_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] max_weight;

    modport source (output valid, max_weight, input ready);
    modport sink (input valid, max_weight, output ready);
endinterface

interface gmw_cfg_if;
    import gmw_pkg::*;
    logic              valid;
    logic              ready;
    logic [ROWS_W-1:0] active_rows;

    modport source (output valid, active_rows, input ready);
    modport sink (input valid, active_rows, output ready);
endinterface
`default_nettype wire

@@ src/grid_max_weight_independent_set_core.sv @@
// Top level: grid maximum-weight independent set core, one column per item.
//
// Channels: "cfg" writes active_rows (reset 8; above 8 acts as 8), taken at any
// cycle with cfg.ready high, to be written only while the block is idle.
// "column" carries eight signed cell weights plus first/last column marks.
// "result" returns max_weight once per grid, after the column marked last.
// Each column runs in the sequencer over the 55 row masks without adjacent
// bits. From accept to ready again, a first column makes one memory write per
// mask, then one final step. Any later column pairs every mask with every
// previous-column mask through the single score memory read port and one
// shared comparator. column.ready is low while a column runs.
// The result sits in an output register; the next column is accepted while it
// waits. Only if a further grid ends before it is taken does the block hold
// in its final step until result.ready. Reset clears the control state and the
// bank select; score memory contents are written by each grid's first column.
`default_nettype none
module grid_max_weight_independent_set_core
    import gmw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gmw_cfg_if.sink    cfg,
    gmw_in_if.sink     column,
    gmw_out_if.source  result
);

    logic [ROWS_W-1:0]     rows_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_free;
    logic                  out_load;
    ctrl_t                 ctrl;
    mem_req_t              mreq;
    logic [SCORE_W-1:0]    rd_data;
    logic [SCORE_W-1:0]    wr_data;
    logic [OUT_W-1:0]      best_out;
    logic signed [W_W-1:0] w_in [MAX_ROWS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_W'(MAX_ROWS);
        end
        else if (cfg.valid)
        begin
            rows_reg <= cfg.active_rows;
        end
    end

    assign w_in[0] = column.weight_0;
    assign w_in[1] = column.weight_1;
    assign w_in[2] = column.weight_2;
    assign w_in[3] = column.weight_3;
    assign w_in[4] = column.weight_4;
    assign w_in[5] = column.weight_5;
    assign w_in[6] = column.weight_6;
    assign w_in[7] = column.weight_7;

    assign out_free       = !out_valid_reg || result.ready;
    assign out_valid_next = out_load || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= best_out;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.max_weight = out_data_reg;

    gmw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (column.valid),
        .in_first (column.first_column),
        .in_last  (column.last_column),
        .out_free (out_free),
        .in_ready (column.ready),
        .out_load (out_load),
        .ctrl     (ctrl),
        .mreq     (mreq)
    );

    gmw_datapath u_datapath (
        .clk      (clk),
        .ctrl     (ctrl),
        .rows     (rows_reg),
        .w_in     (w_in),
        .rd_data  (rd_data),
        .wr_data  (wr_data),
        .best_out (best_out)
    );

    gmw_score_mem u_mem (
        .clk     (clk),
        .req     (mreq),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

@@ src/gmw_score_mem.sv @@
// Score memory: two banks of per-mask scores, one write and one registered read port.
`default_nettype none
module gmw_score_mem
    import gmw_pkg::*;
(
    input  wire logic               clk,
    input  wire mem_req_t           req,
    input  wire logic [SCORE_W-1:0] wr_data,
    output logic      [SCORE_W-1:0] rd_data
);

    logic [SCORE_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ src/gmw_seq.sv @@
// Sequencer: walks current and previous masks, drives memory and datapath control.
`default_nettype none
module gmw_seq
    import gmw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_first,
    input  wire logic     in_last,
    input  wire logic     out_free,
    output logic          in_ready,
    output logic          out_load,
    output ctrl_t         ctrl,
    output mem_req_t      mreq
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] prv_reg, prv_next;
    logic             bank_reg, bank_next;
    logic             first_reg, first_next;
    logic             last_reg, last_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic             accept;

    logic [MAX_ROWS-1:0] cur_mask;
    logic [MAX_ROWS-1:0] prv_mask;

    assign cur_mask = MASKS[cur_reg];
    assign prv_mask = MASKS[prv_reg];
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            prv_reg   <= '0;
            bank_reg  <= 1'b0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            prv_reg   <= prv_next;
            bank_reg  <= bank_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        prv_next   = prv_reg;
        bank_next  = bank_reg;
        first_next = first_reg;
        last_next  = last_reg;
        pend_next  = (state_reg == ST_READ);
        hit_next   = (prv_mask & cur_mask) == '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    first_next = in_first;
                    last_next  = in_last;
                    cur_next   = '0;
                    prv_next   = '0;
                    state_next = in_first ? ST_WRITE : ST_READ;
                end
            end
            ST_READ:
            begin
                prv_next = prv_reg + 1'b1;
                if (prv_reg == LAST_IDX)
                begin
                    prv_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cur_next = cur_reg + 1'b1;
                prv_next = '0;
                if (cur_reg == LAST_IDX)
                begin
                    cur_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = first_reg ? ST_WRITE : ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg || out_free)
                begin
                    bank_next  = ~bank_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        out_load      = (state_reg == ST_FINISH) && last_reg && out_free;
        ctrl.load     = accept;
        ctrl.acc_en   = pend_reg && hit_reg;
        ctrl.wr_en    = (state_reg == ST_WRITE);
        ctrl.cur_mask = cur_mask;
        mreq.rd_en    = (state_reg == ST_READ);
        mreq.rd_addr  = {bank_reg, prv_mask};
        mreq.wr_en    = (state_reg == ST_WRITE);
        mreq.wr_addr  = {~bank_reg, cur_mask};
    end

endmodule
`default_nettype wire

@@ src/gmw_datapath.sv @@
// Datapath: column weights, shared max unit, saturating score add, running best.
`default_nettype none
module gmw_datapath
    import gmw_pkg::*;
(
    input  wire logic                  clk,
    input  wire ctrl_t                 ctrl,
    input  wire logic [ROWS_W-1:0]     rows,
    input  wire logic signed [W_W-1:0] w_in [MAX_ROWS],
    input  wire logic [SCORE_W-1:0]    rd_data,
    output logic      [SCORE_W-1:0]    wr_data,
    output logic      [OUT_W-1:0]      best_out
);

    logic signed [W_W-1:0]     w_reg [MAX_ROWS];
    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic signed [SCORE_W-1:0] all_reg, all_next;
    logic [ROWS_W-1:0]         rows_eff;
    logic signed [COLW_W-1:0]  colw;
    logic signed [SCORE_W:0]   sum;
    logic signed [SCORE_W-1:0] score;
    logic signed [SCORE_W-1:0] cmp_a;
    logic signed [SCORE_W-1:0] cmp_b;
    logic                      gt;

    assign rows_eff = (rows > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                w_reg[r] <= (ROWS_W'(r) < rows_eff) ? w_in[r] : '0;
            end
        end
        best_reg <= best_next;
        all_reg  <= all_next;
    end

    always_comb
    begin
        colw = '0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            if (ctrl.cur_mask[r])
            begin
                colw = colw + COLW_W'(w_reg[r]);
            end
        end
    end

    // saturating add of best compatible score and column weight
    always_comb
    begin
        sum = {best_reg[SCORE_W-1], best_reg} + (SCORE_W + 1)'(colw);
        if (sum[SCORE_W] != sum[SCORE_W-1])
        begin
            score = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                 : {1'b0, {(SCORE_W-1){1'b1}}};
        end
        else
        begin
            score = sum[SCORE_W-1:0];
        end
    end

    // shared compare: read scan during READ and DRAIN, running best during WRITE
    assign cmp_a = ctrl.wr_en ? score : $signed(rd_data);
    assign cmp_b = ctrl.wr_en ? all_reg : best_reg;
    assign gt    = cmp_a > cmp_b;

    always_comb
    begin
        best_next = best_reg;
        all_next  = all_reg;
        if (ctrl.load)
        begin
            best_next = '0;
            all_next  = '0;
        end
        else if (ctrl.wr_en)
        begin
            best_next = '0;
            if (gt)
            begin
                all_next = score;
            end
        end
        else if (ctrl.acc_en && gt)
        begin
            best_next = cmp_a;
        end
    end

    assign wr_data  = score;
    assign best_out = all_reg[OUT_W-1:0];

endmodule
`default_nettype wire
